@@ src/stsub_pkg.sv @@
`timescale 1ns / 1ps
package stsub_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int FIELD_W    = 16;
    localparam int TEX_W      = 15;
    localparam int NORM_EXTRA = 13;

    // edge sum and its squared length
    localparam int SUM_W  = FIELD_W + 1;
    localparam int N2_W   = 2 * SUM_W;

    // length = isqrt(n2 << 2*NORM_EXTRA), worked three root bits a cycle
    localparam int ROOT_SH  = 2 * NORM_EXTRA;
    localparam int RAD_W    = N2_W + ROOT_SH;
    localparam int LEN_W    = (RAD_W + 1) / 2;
    localparam int SQ_STEPS = 3;
    localparam int SQ_CYC   = (LEN_W + SQ_STEPS - 1) / SQ_STEPS;
    localparam int LENP_W   = SQ_STEPS * SQ_CYC;
    localparam int RADP_W   = 2 * LENP_W;
    localparam int REM_W    = LENP_W + 3;
    localparam int SQC_W    = $clog2(SQ_CYC + 1);

    // component scale: ((|s| << NUM_SH) + len/2) / len, result clamped to ONE
    localparam int NUM_SH    = FRAC_BITS + NORM_EXTRA;
    localparam int QW        = FRAC_BITS + 1;
    localparam int DIV_STEPS = 3;
    localparam int DIV_CYC   = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DQ        = DIV_STEPS * DIV_CYC;
    localparam int NUM_W     = SUM_W + NUM_SH + 1;
    localparam int DREM_W    = LENP_W + 1;
    localparam int DVC_W     = $clog2(DIV_CYC + 1);

    localparam int NUM_VTX  = 12;
    localparam int IDX_W    = $clog2(NUM_VTX);
    localparam int TEXT_W   = (FIELD_W > FRAC_BITS ? FIELD_W : FRAC_BITS) + 2;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
    } t_vec;

    typedef struct packed {
        t_vec p;
        t_vec q;
    } t_pair;

    typedef struct packed {
        t_vec m;
        t_vec p;
        t_vec q;
    } t_lane_res;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec c;
        t_vec mab;
        t_vec mac;
        t_vec mbc;
    } t_tri;

endpackage

@@ src/stsub_in_if.sv @@
`timescale 1ns / 1ps
interface stsub_in_if import stsub_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by_coord;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

@@ src/stsub_out_if.sv @@
`timescale 1ns / 1ps
interface stsub_out_if import stsub_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] vx;
    logic signed [FIELD_W-1:0] vy;
    logic signed [FIELD_W-1:0] vz;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
    logic                      last_vertex;

    modport source (output valid, vx, vy, vz, tex_u, tex_v, last_vertex, input ready);
    modport sink   (input valid, vx, vy, vz, tex_u, tex_v, last_vertex, output ready);
endinterface

@@ src/stsub_lane.sv @@
`timescale 1ns / 1ps
module stsub_lane import stsub_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_pair     i_pair,
    output logic      o_valid,
    input  logic      i_ready,
    output t_lane_res o_res
);

    // stage 1: sums and squares
    logic                     r1_v;
    t_pair                    r1_pair;
    logic signed [SUM_W-1:0]  r1_s  [3];
    logic [N2_W-1:0]          r1_sq [3];

    // stage 2: square root unit
    logic                     rq_v;
    logic [SQC_W-1:0]         rq_cnt;
    logic [RADP_W-1:0]        rq_rad;
    logic [REM_W-1:0]         rq_rem;
    logic [LENP_W-1:0]        rq_root;
    logic                     rq_zero;
    logic signed [SUM_W-1:0]  rq_s [3];
    t_pair                    rq_pair;

    // stage 3: three dividers sharing one length
    logic                     rd_v;
    logic [DVC_W-1:0]         rd_cnt;
    logic [LENP_W-1:0]        rd_len;
    logic [DREM_W-1:0]        rd_rem [3];
    logic [DQ-1:0]            rd_num [3];
    logic [DQ-1:0]            rd_q   [3];
    logic                     rd_neg [3];
    logic                     rd_zero;
    t_pair                    rd_pair;

    logic                     s1_take, sq_done, sq_take, sq_free, div_take, div_free;
    logic signed [SUM_W-1:0]  w_s [3];
    logic [N2_W-1:0]          w_n2;
    logic [RADP_W-1:0]        n_q_rad;
    logic [REM_W-1:0]         n_q_rem;
    logic [LENP_W-1:0]        n_q_root;
    logic [DREM_W-1:0]        n_d_rem [3];
    logic [DQ-1:0]            n_d_num [3];
    logic [DQ-1:0]            n_d_q   [3];
    logic [NUM_W-1:0]         w_num   [3];
    logic [SUM_W-1:0]         w_mag   [3];
    logic [FIELD_W-1:0]       w_m     [3];

    assign o_valid  = rd_v && (rd_cnt == '0);
    assign div_take = o_valid && i_ready;
    assign div_free = !rd_v || div_take;
    assign sq_done  = rq_v && (rq_cnt == '0);
    assign sq_take  = sq_done && div_free;
    assign sq_free  = !rq_v || sq_take;
    assign s1_take  = r1_v && sq_free;
    assign o_ready  = !r1_v || s1_take;

    assign w_s[0] = SUM_W'($signed(i_pair.p.x)) + SUM_W'($signed(i_pair.q.x));
    assign w_s[1] = SUM_W'($signed(i_pair.p.y)) + SUM_W'($signed(i_pair.q.y));
    assign w_s[2] = SUM_W'($signed(i_pair.p.z)) + SUM_W'($signed(i_pair.q.z));
    assign w_n2   = r1_sq[0] + r1_sq[1] + r1_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (o_ready) begin
            r1_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r1_pair <= i_pair;
            for (int i = 0; i < 3; i++) begin
                r1_s[i]  <= w_s[i];
                r1_sq[i] <= N2_W'($unsigned(N2_W'(w_s[i]) * N2_W'(w_s[i])));
            end
        end
    end

    // digit-by-digit square root, SQ_STEPS result bits a cycle
    always_comb begin
        n_q_rem  = rq_rem;
        n_q_root = rq_root;
        n_q_rad  = rq_rad;
        for (int k = 0; k < SQ_STEPS; k++) begin
            n_q_rem = {n_q_rem[REM_W-3:0], n_q_rad[RADP_W-1 -: 2]};
            n_q_rad = n_q_rad << 2;
            if (n_q_rem >= REM_W'({n_q_root, 2'b01})) begin
                n_q_rem  = n_q_rem - REM_W'({n_q_root, 2'b01});
                n_q_root = {n_q_root[LENP_W-2:0], 1'b1};
            end else begin
                n_q_root = {n_q_root[LENP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_v   <= 1'b0;
            rq_cnt <= '0;
        end else if (s1_take) begin
            rq_v   <= 1'b1;
            rq_cnt <= SQC_W'(SQ_CYC);
        end else if (sq_take) begin
            rq_v   <= 1'b0;
        end else if (rq_v && rq_cnt != '0) begin
            rq_cnt <= rq_cnt - 1'b1;
        end
        if (s1_take) begin
            rq_rad  <= RADP_W'({w_n2, {ROOT_SH{1'b0}}});
            rq_rem  <= '0;
            rq_root <= '0;
            rq_zero <= (w_n2 == '0);
            rq_s    <= r1_s;
            rq_pair <= r1_pair;
        end else if (rq_v && rq_cnt != '0) begin
            rq_rad  <= n_q_rad;
            rq_rem  <= n_q_rem;
            rq_root <= n_q_root;
        end
    end

    // restoring division, DIV_STEPS quotient bits a cycle per component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = rq_s[i][SUM_W-1] ? SUM_W'(-rq_s[i]) : SUM_W'(rq_s[i]);
            w_num[i] = (NUM_W'(w_mag[i]) << NUM_SH) + NUM_W'(rq_root >> 1);
            n_d_rem[i] = rd_rem[i];
            n_d_num[i] = rd_num[i];
            n_d_q[i]   = rd_q[i];
            for (int k = 0; k < DIV_STEPS; k++) begin
                n_d_rem[i] = {n_d_rem[i][DREM_W-2:0], n_d_num[i][DQ-1]};
                n_d_num[i] = n_d_num[i] << 1;
                if (n_d_rem[i] >= DREM_W'(rd_len)) begin
                    n_d_rem[i] = n_d_rem[i] - DREM_W'(rd_len);
                    n_d_q[i]   = {n_d_q[i][DQ-2:0], 1'b1};
                end else begin
                    n_d_q[i]   = {n_d_q[i][DQ-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v   <= 1'b0;
            rd_cnt <= '0;
        end else if (sq_take) begin
            rd_v   <= 1'b1;
            rd_cnt <= DVC_W'(DIV_CYC);
        end else if (div_take) begin
            rd_v   <= 1'b0;
        end else if (rd_v && rd_cnt != '0) begin
            rd_cnt <= rd_cnt - 1'b1;
        end
        if (sq_take) begin
            rd_len  <= rq_root;
            rd_zero <= rq_zero;
            rd_pair <= rq_pair;
            for (int i = 0; i < 3; i++) begin
                rd_rem[i] <= DREM_W'(w_num[i] >> DQ);
                rd_num[i] <= w_num[i][DQ-1:0];
                rd_q[i]   <= '0;
                rd_neg[i] <= rq_s[i][SUM_W-1];
            end
        end else if (rd_v && rd_cnt != '0) begin
            rd_rem <= n_d_rem;
            rd_num <= n_d_num;
            rd_q   <= n_d_q;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (rd_zero) begin
                w_m[i] = '0;
            end else if (rd_q[i] > DQ'(ONE)) begin
                w_m[i] = rd_neg[i] ? FIELD_W'(-ONE) : FIELD_W'(ONE);
            end else begin
                w_m[i] = rd_neg[i] ? -FIELD_W'(rd_q[i]) : FIELD_W'(rd_q[i]);
            end
        end
    end

    assign o_res.m.x = w_m[0];
    assign o_res.m.y = w_m[1];
    assign o_res.m.z = w_m[2];
    assign o_res.p   = rd_pair.p;
    assign o_res.q   = rd_pair.q;

endmodule

@@ src/stsub_emit.sv @@
`timescale 1ns / 1ps
module stsub_emit import stsub_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_tri         i_tri,
    stsub_out_if.source  o_vtx
);

    logic             r_have;
    logic [IDX_W-1:0] r_idx;
    t_tri             r_tri;
    logic             r_ov;
    t_vec             r_v;
    logic [TEX_W-1:0] r_tu;
    logic [TEX_W-1:0] r_tv;
    logic             r_last;

    logic             w_adv;
    logic             w_end;
    t_vec             w_sel;

    function automatic logic [TEX_W-1:0] f_tex(input logic [FIELD_W-1:0] c);
        logic signed [TEXT_W-1:0] t;
        t = TEXT_W'($signed(c)) + TEXT_W'(ONE);
        if (t < 0) begin
            t = '0;
        end
        t = t >>> 1;
        if (t > TEXT_W'(ONE)) begin
            t = TEXT_W'(ONE);
        end
        return TEX_W'(t);
    endfunction

    assign w_adv   = r_have && (!r_ov || o_vtx.ready);
    assign w_end   = (r_idx == IDX_W'(NUM_VTX - 1));
    assign o_ready = !r_have || (w_adv && w_end);

    always_comb begin
        case (r_idx)
            IDX_W'(0):  w_sel = r_tri.a;
            IDX_W'(1):  w_sel = r_tri.mab;
            IDX_W'(2):  w_sel = r_tri.mac;
            IDX_W'(3):  w_sel = r_tri.mab;
            IDX_W'(4):  w_sel = r_tri.b;
            IDX_W'(5):  w_sel = r_tri.mbc;
            IDX_W'(6):  w_sel = r_tri.mbc;
            IDX_W'(7):  w_sel = r_tri.mac;
            IDX_W'(8):  w_sel = r_tri.mab;
            IDX_W'(9):  w_sel = r_tri.mac;
            IDX_W'(10): w_sel = r_tri.mbc;
            default:    w_sel = r_tri.c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_ready && i_valid) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv) begin
                r_have <= !w_end;
                r_idx  <= r_idx + 1'b1;
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (o_vtx.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (o_ready && i_valid) begin
            r_tri <= i_tri;
        end
        if (w_adv) begin
            r_v    <= w_sel;
            r_tu   <= f_tex(w_sel.x);
            r_tv   <= f_tex(w_sel.y);
            r_last <= w_end;
        end
    end

    assign o_vtx.valid       = r_ov;
    assign o_vtx.vx          = r_v.x;
    assign o_vtx.vy          = r_v.y;
    assign o_vtx.vz          = r_v.z;
    assign o_vtx.tex_u       = r_tu;
    assign o_vtx.tex_v       = r_tv;
    assign o_vtx.last_vertex = r_last;

endmodule

@@ src/sphere_triangle_subdivider.sv @@
`timescale 1ns / 1ps
// Path from triangle accepted to first vertex offered: sum/square register,
// square root unit, divide unit, merge register, output register.
// One vertex a cycle at the output port while the port is ready; each lane can
// take a new triangle into stage 1 while its square root unit is still busy.
// Reset (synchronous, active low) clears all valid flags; in-flight data is dropped.
module sphere_triangle_subdivider import stsub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stsub_in_if.sink    i_tri,
    stsub_out_if.source o_vtx
);

    t_vec      w_a, w_b, w_c;
    t_pair     w_pab, w_pac, w_pbc;
    t_lane_res w_rab, w_rac, w_rbc;
    logic      w_rdy_ab, w_rdy_ac, w_rdy_bc, w_all_rdy, w_lane_in_v;
    logic      w_v_ab, w_v_ac, w_v_bc, w_all_v;
    logic      w_emit_rdy, w_lane_take;
    t_tri      w_tri;

    assign w_a = '{x: i_tri.ax, y: i_tri.ay, z: i_tri.az};
    assign w_b = '{x: i_tri.bx, y: i_tri.by_coord, z: i_tri.bz};
    assign w_c = '{x: i_tri.cx, y: i_tri.cy, z: i_tri.cz};

    assign w_pab = '{p: w_a, q: w_b};
    assign w_pac = '{p: w_a, q: w_c};
    assign w_pbc = '{p: w_b, q: w_c};

    assign w_all_rdy   = w_rdy_ab && w_rdy_ac && w_rdy_bc;
    assign i_tri.ready = w_all_rdy;
    assign w_lane_in_v = i_tri.valid && w_all_rdy;
    assign w_all_v     = w_v_ab && w_v_ac && w_v_bc;
    assign w_lane_take = w_all_v && w_emit_rdy;

    stsub_lane u_lane_ab (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_lane_in_v), .o_ready(w_rdy_ab), .i_pair(w_pab),
        .o_valid(w_v_ab), .i_ready(w_lane_take), .o_res(w_rab)
    );

    stsub_lane u_lane_ac (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_lane_in_v), .o_ready(w_rdy_ac), .i_pair(w_pac),
        .o_valid(w_v_ac), .i_ready(w_lane_take), .o_res(w_rac)
    );

    stsub_lane u_lane_bc (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_lane_in_v), .o_ready(w_rdy_bc), .i_pair(w_pbc),
        .o_valid(w_v_bc), .i_ready(w_lane_take), .o_res(w_rbc)
    );

    // corners ride with the lanes so they stay matched to their midpoints
    assign w_tri = '{a: w_rab.p, b: w_rbc.p, c: w_rbc.q,
                     mab: w_rab.m, mac: w_rac.m, mbc: w_rbc.m};

    stsub_emit u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_all_v), .o_ready(w_emit_rdy), .i_tri(w_tri),
        .o_vtx(o_vtx)
    );

    // lanes are loaded together and run fixed-length, so they finish together
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v_ab == w_v_ac) && (w_v_ac == w_v_bc))
        else $error("lanes out of step");

    a_ready_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy_ab == w_rdy_ac) && (w_rdy_ac == w_rdy_bc))
        else $error("lane readiness out of step");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid |-> (o_vtx.tex_u <= TEX_W'(ONE)) && (o_vtx.tex_v <= TEX_W'(ONE)))
        else $error("texture coordinate out of range");

    a_last_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid && o_vtx.ready && o_vtx.last_vertex |=> !o_vtx.valid || !o_vtx.last_vertex)
        else $error("last vertex repeated");

endmodule

@@ test/sphere_triangle_subdivider_tb.sv @@
`timescale 1ns / 1ps
module sphere_triangle_subdivider_tb;
    import stsub_pkg::*;

    typedef struct {
        logic signed [FIELD_W-1:0] x, y, z;
    } t_vert;

    typedef struct {
        logic signed [FIELD_W-1:0] vx, vy, vz;
        logic [TEX_W-1:0]          tu, tv;
        logic                      last;
    } t_vertex_out;

    logic i_clk;
    logic i_rst_n;
    stsub_in_if  tri_ch ();
    stsub_out_if vtx_ch ();

    sphere_triangle_subdivider DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .o_vtx   (vtx_ch.source)
    );

    t_vertex_out expected_vertices[$];
    int  n_errors;
    longint cycle_count;
    bit  idle_enable;
    bit  timed_out;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("[sphere_triangle_subdivider] ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        n_errors++;
    endtask

    function automatic longint root_floor(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_vert sphere_mid(input t_vert p, input t_vert q);
        longint sx, sy, sz, s[3], mag, qv;
        longint unsigned n2, len;
        t_vert m;
        sx = longint'(p.x) + longint'(q.x);
        sy = longint'(p.y) + longint'(q.y);
        sz = longint'(p.z) + longint'(q.z);
        n2 = sx * sx + sy * sy + sz * sz;
        m.x = '0; m.y = '0; m.z = '0;
        if (n2 == 0) return m;
        len = root_floor(n2 << 26);
        s[0] = sx; s[1] = sy; s[2] = sz;
        for (int i = 0; i < 3; i++) begin
            mag = s[i] < 0 ? -s[i] : s[i];
            qv = ((mag << (FRAC_BITS + NORM_EXTRA)) + longint'(len >> 1)) / longint'(len);
            if (qv > ONE) qv = ONE;
            if (s[i] < 0) qv = -qv;
            s[i] = qv;
        end
        m.x = FIELD_W'(s[0]); m.y = FIELD_W'(s[1]); m.z = FIELD_W'(s[2]);
        return m;
    endfunction

    function automatic logic [TEX_W-1:0] planar_tex(input logic signed [FIELD_W-1:0] c);
        longint t;
        t = longint'(c) + ONE;
        if (t < 0) t = 0;
        t = t / 2;
        if (t > ONE) t = ONE;
        return t[TEX_W-1:0];
    endfunction

    task automatic predict_subdivision(input t_vert a, input t_vert b, input t_vert c);
        t_vert mab, mac, mbc, seq[12];
        t_vertex_out e;
        mab = sphere_mid(a, b);
        mac = sphere_mid(a, c);
        mbc = sphere_mid(b, c);
        seq = '{a, mab, mac, mab, b, mbc, mbc, mac, mab, mac, mbc, c};
        for (int k = 0; k < NUM_VTX; k++) begin
            e.vx = seq[k].x; e.vy = seq[k].y; e.vz = seq[k].z;
            e.tu = planar_tex(seq[k].x);
            e.tv = planar_tex(seq[k].y);
            e.last = (k == NUM_VTX - 1);
            expected_vertices = {expected_vertices, e};
        end
    endtask

    task automatic send_triangle(input t_vert a, input t_vert b, input t_vert c);
        while (idle_enable && $urandom_range(99) < 38) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid    <= 1'b1;
        tri_ch.ax <= a.x; tri_ch.ay <= a.y; tri_ch.az <= a.z;
        tri_ch.bx <= b.x; tri_ch.by_coord <= b.y; tri_ch.bz <= b.z;
        tri_ch.cx <= c.x; tri_ch.cy <= c.y; tri_ch.cz <= c.z;
        predict_subdivision(a, b, c);
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
    endtask

    // output side: random stall, then compare each accepted vertex
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx_ch.ready <= 1'b0;
        end else begin
            if (vtx_ch.valid && vtx_ch.ready) begin
                if (expected_vertices.size() == 0) begin
                    report("unexpected vertex", 0, 0);
                end else begin
                    t_vertex_out e;
                    e = expected_vertices.pop_front();
                    if (vtx_ch.vx !== e.vx) report("vx", vtx_ch.vx, e.vx);
                    if (vtx_ch.vy !== e.vy) report("vy", vtx_ch.vy, e.vy);
                    if (vtx_ch.vz !== e.vz) report("vz", vtx_ch.vz, e.vz);
                    if (vtx_ch.tex_u !== e.tu) report("tex_u", vtx_ch.tex_u, e.tu);
                    if (vtx_ch.tex_v !== e.tv) report("tex_v", vtx_ch.tex_v, e.tv);
                    if (vtx_ch.last_vertex !== e.last)
                        report("last_vertex", vtx_ch.last_vertex, e.last);
                end
            end
            vtx_ch.ready <= !(idle_enable && $urandom_range(99) < 38);
        end
    end

    function automatic logic signed [FIELD_W-1:0] rand_coord();
        return FIELD_W'(int'($urandom_range(2 * ONE)) - ONE);
    endfunction

    function automatic t_vert rand_vert();
        t_vert v;
        v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
        return v;
    endfunction

    // a roughly unit vector: one axis near +-ONE, the others small
    function automatic t_vert rand_unit();
        t_vert v;
        int ax_sel;
        int big;
        v.x = FIELD_W'(int'($urandom_range(4000)) - 2000);
        v.y = FIELD_W'(int'($urandom_range(4000)) - 2000);
        v.z = FIELD_W'(int'($urandom_range(4000)) - 2000);
        ax_sel = $urandom_range(2);
        big = ONE - int'($urandom_range(300));
        if ($urandom_range(1) == 0) big = -big;
        if (ax_sel == 0) v.x = FIELD_W'(big);
        if (ax_sel == 1) v.y = FIELD_W'(big);
        if (ax_sel == 2) v.z = FIELD_W'(big);
        return v;
    endfunction

    function automatic t_vert mk(input int x, input int y, input int z);
        t_vert v;
        v.x = FIELD_W'(x); v.y = FIELD_W'(y); v.z = FIELD_W'(z);
        return v;
    endfunction

    function automatic t_vert negv(input t_vert v);
        return mk(-int'(v.x), -int'(v.y), -int'(v.z));
    endfunction

    task automatic test_octahedron_faces();
        send_triangle(mk(ONE, 0, 0), mk(0, ONE, 0), mk(0, 0, ONE));
        send_triangle(mk(-ONE, 0, 0), mk(0, -ONE, 0), mk(0, 0, -ONE));
        send_triangle(mk(ONE, 0, 0), mk(0, 0, -ONE), mk(0, -ONE, 0));
        send_triangle(mk(0, ONE, 0), mk(-ONE, 0, 0), mk(0, 0, ONE));
    endtask

    task automatic test_zero_length_midpoints();
        t_vert v;
        v = rand_unit();
        send_triangle(v, negv(v), rand_unit());
        send_triangle(mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0));
        send_triangle(mk(ONE, ONE, ONE), mk(-ONE, -ONE, -ONE), mk(0, 0, ONE));
        send_triangle(mk(0, 0, 0), mk(1, 0, 0), mk(0, -1, 0));
    endtask

    task automatic test_extreme_patterns();
        // out-of-range corners: clamped texture, large sums
        send_triangle(mk(32767, 32767, 32767), mk(32767, 32767, 32767), mk(-32768, -32768, -32768));
        send_triangle(mk(-32768, 32767, -32768), mk(-32768, -32768, 32767), mk(32767, -32768, 0));
        send_triangle(mk(16'h5555, 16'hAAAA, 16'h5555), mk(16'hAAAA, 16'h5555, 16'hAAAA),
                      mk(16'hFFFF, 16'h0001, 16'h8001));
        send_triangle(mk(ONE, ONE, ONE), mk(ONE, ONE, ONE), mk(ONE, ONE, ONE));
        send_triangle(mk(-ONE, -ONE, -ONE), mk(-ONE, -ONE, 0), mk(0, -ONE, -ONE));
        send_triangle(mk(-ONE - 1, ONE + 1, -ONE - 2), mk(1, -1, 0), mk(-ONE - 3, ONE + 3, 5));
    endtask

    task automatic test_random_triangles(input int count);
        t_vert a, b, c;
        for (int i = 0; i < count; i++) begin
            idle_enable = !(i >= count / 3 && i < count / 3 + 60);
            case ($urandom_range(9))
                0: begin
                    a = mk($urandom, $urandom, $urandom);
                    b = mk($urandom, $urandom, $urandom);
                    c = mk($urandom, $urandom, $urandom);
                end
                1, 2, 3: begin
                    a = rand_vert(); b = rand_vert(); c = rand_vert();
                end
                4: begin
                    a = rand_unit(); b = negv(a); c = rand_unit();
                end
                default: begin
                    a = rand_unit(); b = rand_unit(); c = rand_unit();
                end
            endcase
            send_triangle(a, b, c);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        n_errors = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        i_rst_n = 1'b0;
        tri_ch.valid = 1'b0;
        {tri_ch.ax, tri_ch.ay, tri_ch.az} = '0;
        {tri_ch.bx, tri_ch.by_coord, tri_ch.bz} = '0;
        {tri_ch.cx, tri_ch.cy, tri_ch.cz} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_octahedron_faces();
        test_zero_length_midpoints();
        test_extreme_patterns();
        test_random_triangles(440);
        tri_ch.valid <= 1'b0;

        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && expected_vertices.size() == 0) begin
            $display("[sphere_triangle_subdivider] OK");
        end else begin
            $display("[sphere_triangle_subdivider] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/stsub_pkg.sv
src/stsub_in_if.sv
src/stsub_out_if.sv
src/stsub_lane.sv
src/stsub_emit.sv
src/sphere_triangle_subdivider.sv
test/sphere_triangle_subdivider_tb.sv
